[rtl/heightfield_triangle_sampler_assert.svh]
// Assertion macros shared by the checker.
`ifndef HEIGHTFIELD_TRIANGLE_SAMPLER_ASSERT_SVH
`define HEIGHTFIELD_TRIANGLE_SAMPLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hts_pkg.sv]
package hts_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 65536;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int DIV_W      = 32 + FRAC_BITS;
  localparam int DIV_STAGES = DIV_W + 1;
  localparam int CELL_W     = 25;
  localparam int DIM_W      = 9;
  localparam int IDX_W      = 2 * DIM_W + 1;
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int PROD_W     = 32 + WGT_W + 1;
  localparam int PADDR_W    = 5;

  localparam logic [2:0] REG_COLS  = 3'd0;
  localparam logic [2:0] REG_ROWS  = 3'd1;
  localparam logic [2:0] REG_CELL  = 3'd2;
  localparam logic [2:0] REG_ORG_X = 3'd3;
  localparam logic [2:0] REG_ORG_Y = 3'd4;

  localparam logic [DIM_W-1:0]  COLS_RST = 9'd256;
  localparam logic [DIM_W-1:0]  ROWS_RST = 9'd256;
  localparam logic [CELL_W-1:0] CELL_RST = 25'd65536;

  localparam logic       ACT_WRITE = 1'b0;
  localparam logic       ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
    logic [CELL_W-1:0] cell_sz;
    logic [31:0]       origin_x;
    logic [31:0]       origin_y;
  } cfg_t;

  // item leaving the divider pipe
  typedef struct packed {
    logic              action;
    logic [15:0]       index;
    logic [31:0]       height;
    logic              early_out;
    logic [DIV_W-1:0]  qx;
    logic [DIV_W-1:0]  qy;
  } tail_t;

endpackage

[rtl/hts_if.sv]
interface hts_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] sample_index;
  logic [31:0] sample_height;
  logic [31:0] query_x;
  logic [31:0] query_y;

  modport source (output valid, action, sample_index, sample_height, query_x, query_y,
                  input ready);
  modport sink (input valid, action, sample_index, sample_height, query_x, query_y,
                output ready);
endinterface

interface hts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] height;
  logic        outside;

  modport source (output valid, height, outside, input ready);
  modport sink (input valid, height, outside, output ready);
endinterface

[rtl/hts_ram.sv]
module hts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hts_divpipe.sv]
module hts_divpipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hts_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_action_i,
  input  logic [15:0]    in_index_i,
  input  logic [31:0]    in_height_i,
  input  logic [31:0]    in_qx_i,
  input  logic [31:0]    in_qy_i,
  output logic           tail_valid_o,
  input  logic           tail_ready_i,
  output hts_pkg::tail_t tail_o
);
  import hts_pkg::*;

  typedef struct packed {
    logic [CELL_W-1:0] rem;
    logic [DIV_W-1:0]  sh;
  } step_t;

  // one restoring-division step: quotient bit shifts in at the bottom
  function automatic step_t div_step(step_t s, logic [CELL_W-1:0] d);
    logic [CELL_W:0] trial;
    logic [CELL_W:0] diff;
    step_t           r;
    trial = {s.rem, s.sh[DIV_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      r.rem = diff[CELL_W-1:0];
      r.sh  = {s.sh[DIV_W-2:0], 1'b1};
    end else begin
      r.rem = trial[CELL_W-1:0];
      r.sh  = {s.sh[DIV_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [DIV_STAGES-1:0] valid_q;
  step_t                 st_x_q  [DIV_STAGES];
  step_t                 st_y_q  [DIV_STAGES];
  logic                  act_q   [DIV_STAGES];
  logic [15:0]           idx_q   [DIV_STAGES];
  logic [31:0]           hgt_q   [DIV_STAGES];
  logic                  early_q [DIV_STAGES];

  logic        adv;
  logic [32:0] lx, ly;
  logic        early;

  assign adv        = !valid_q[DIV_STAGES-1] || tail_ready_i;
  assign in_ready_o = adv;

  assign lx = {in_qx_i[31], in_qx_i} - {cfg_i.origin_x[31], cfg_i.origin_x};
  assign ly = {cfg_i.origin_y[31], cfg_i.origin_y} - {in_qy_i[31], in_qy_i};
  assign early = lx[32] || ly[32] || (cfg_i.cols < 9'd2) || (cfg_i.rows < 9'd2) ||
                 (cfg_i.cell_sz == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[DIV_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_x_q[0]  <= '{rem: '0, sh: {lx[31:0], {FRAC_BITS{1'b0}}}};
      st_y_q[0]  <= '{rem: '0, sh: {ly[31:0], {FRAC_BITS{1'b0}}}};
      act_q[0]   <= in_action_i;
      idx_q[0]   <= in_index_i;
      hgt_q[0]   <= in_height_i;
      early_q[0] <= early;
      for (int i = 1; i < DIV_STAGES; i++) begin
        st_x_q[i]  <= div_step(st_x_q[i-1], cfg_i.cell_sz);
        st_y_q[i]  <= div_step(st_y_q[i-1], cfg_i.cell_sz);
        act_q[i]   <= act_q[i-1];
        idx_q[i]   <= idx_q[i-1];
        hgt_q[i]   <= hgt_q[i-1];
        early_q[i] <= early_q[i-1];
      end
    end
  end

  assign tail_valid_o     = valid_q[DIV_STAGES-1];
  assign tail_o.action    = act_q[DIV_STAGES-1];
  assign tail_o.index     = idx_q[DIV_STAGES-1];
  assign tail_o.height    = hgt_q[DIV_STAGES-1];
  assign tail_o.early_out = early_q[DIV_STAGES-1];
  assign tail_o.qx        = st_x_q[DIV_STAGES-1].sh;
  assign tail_o.qy        = st_y_q[DIV_STAGES-1].sh;

endmodule

[rtl/hts_lookup.sv]
module hts_lookup (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hts_pkg::cfg_t  cfg_i,
  input  logic           tail_valid_i,
  output logic           tail_ready_o,
  input  hts_pkg::tail_t tail_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    out_height_o,
  output logic           out_outside_o
);
  import hts_pkg::*;

  localparam logic [WGT_W-1:0]  ONE  = WGT_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  // ---- cell decode of the item at the pipe tail ----
  logic [31:0]          gx, gy;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [DIM_W-1:0]     lim_x, lim_y;
  logic [2*DIM_W-1:0]   col_base;
  logic [IDX_W-1:0]     base, i00, i10, i01, i11;
  logic [WGT_W-1:0]     fsum;
  logic                 lower, oob;

  assign gx       = tail_i.qx[DIV_W-1:FRAC_BITS];
  assign gy       = tail_i.qy[DIV_W-1:FRAC_BITS];
  assign fx       = tail_i.qx[FRAC_BITS-1:0];
  assign fy       = tail_i.qy[FRAC_BITS-1:0];
  assign lim_x    = cfg_i.cols - 9'd2;
  assign lim_y    = cfg_i.rows - 9'd2;
  assign col_base = gx[DIM_W-1:0] * cfg_i.rows;
  assign base     = IDX_W'(col_base);
  assign i00      = base + IDX_W'(gy[DIM_W-1:0]);
  assign i10      = i00 + IDX_W'(cfg_i.rows);
  assign i01      = i00 + IDX_W'(1);
  assign i11      = i10 + IDX_W'(1);
  assign fsum     = {1'b0, fx} + {1'b0, fy};
  assign lower    = fsum <= ONE;
  assign oob      = tail_i.early_out || (gx > {23'd0, lim_x}) || (gy > {23'd0, lim_y}) ||
                    (i11 >= IDX_W'(MAX_POINTS));

  // ---- job registers: up to three reads of one query ----
  logic [ADDR_W-1:0] j_addr_q [3];
  logic [WGT_W-1:0]  j_w_q    [3];
  logic              j_out_q;
  logic [1:0]        j_left_q, j_pos_q;
  logic              busy;

  logic [1:0] inflight_q, occ_q;
  logic       credit, can_start, do_write, wr_ok;

  assign busy      = j_left_q != 2'd0;
  assign credit    = ({1'b0, inflight_q} + {1'b0, occ_q}) < 3'd2;
  assign can_start = tail_valid_i && (tail_i.action == ACT_QUERY) && !busy && credit;
  assign do_write  = tail_valid_i && (tail_i.action == ACT_WRITE) && !busy;
  assign wr_ok     = IDX_W'(tail_i.index) < IDX_W'(MAX_POINTS);
  assign tail_ready_o = can_start || do_write;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_left_q <= '0;
      j_pos_q  <= '0;
    end else if (can_start) begin
      j_left_q <= oob ? 2'd1 : 2'd3;
      j_pos_q  <= '0;
    end else if (busy) begin
      j_left_q <= j_left_q - 2'd1;
      j_pos_q  <= j_pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_start) begin
      j_out_q <= oob;
      if (lower) begin
        j_addr_q[0] <= i00[ADDR_W-1:0];
        j_addr_q[1] <= i10[ADDR_W-1:0];
        j_addr_q[2] <= i01[ADDR_W-1:0];
        j_w_q[0]    <= ONE - fsum;
        j_w_q[1]    <= {1'b0, fx};
        j_w_q[2]    <= {1'b0, fy};
      end else begin
        j_addr_q[0] <= i10[ADDR_W-1:0];
        j_addr_q[1] <= i11[ADDR_W-1:0];
        j_addr_q[2] <= i01[ADDR_W-1:0];
        j_w_q[0]    <= ONE - {1'b0, fy};
        j_w_q[1]    <= fsum - ONE;
        j_w_q[2]    <= ONE - {1'b0, fx};
      end
    end
  end

  // ---- height store ----
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       ram_rdata;

  assign ram_we   = do_write && wr_ok;
  assign ram_addr = do_write ? tail_i.index[ADDR_W-1:0] : j_addr_q[j_pos_q];

  hts_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (tail_i.height),
    .rdata_o (ram_rdata)
  );

  // ---- multiply-accumulate: read data, product, sum ----
  logic                     b_valid_q, b_first_q, b_last_q, b_out_q;
  logic [WGT_W-1:0]         b_w_q;
  logic                     c_valid_q, c_first_q, c_last_q, c_out_q;
  logic [PROD_W-1:0]        prod_q, acc_q, acc_sum, rnd;
  logic signed [PROD_W-1:0] mul;
  logic                     push, pop;

  // signed 32 x 18 product, extended to the accumulator width
  assign mul = $signed(ram_rdata) * $signed({1'b0, b_w_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      b_valid_q <= busy;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_first_q <= j_pos_q == 2'd0;
    b_last_q  <= j_left_q == 2'd1;
    b_out_q   <= j_out_q;
    b_w_q     <= j_w_q[j_pos_q];
    c_first_q <= b_first_q;
    c_last_q  <= b_last_q;
    c_out_q   <= b_out_q;
    prod_q    <= b_out_q ? '0 : mul;
    if (c_valid_q) begin
      acc_q <= acc_sum;
    end
  end

  assign acc_sum = (c_first_q ? '0 : acc_q) + prod_q;
  assign rnd     = acc_sum + HALF;   // ties go up
  assign push    = c_valid_q && c_last_q;

  // ---- two-entry result queue ----
  logic [31:0] q_hgt_q [2];
  logic        q_out_q [2];
  logic        wr_ptr_q, rd_ptr_q;

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      occ_q      <= '0;
      inflight_q <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      occ_q      <= occ_q + {1'b0, push} - {1'b0, pop};
      inflight_q <= inflight_q + {1'b0, can_start} - {1'b0, push};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_hgt_q[wr_ptr_q] <= c_out_q ? 32'd0 : rnd[FRAC_BITS +: 32];
      q_out_q[wr_ptr_q] <= c_out_q;
    end
  end

  assign out_valid_o   = occ_q != 2'd0;
  assign out_height_o  = q_hgt_q[rd_ptr_q];
  assign out_outside_o = q_out_q[rd_ptr_q];

endmodule

[rtl/heightfield_triangle_sampler.sv]
// channel  | dir | transaction carries
// ---------+-----+---------------------------------------------------------
// in_i     | in  | action, sample_index, sample_height, query_x, query_y
// out_o    | out | height, outside (one per query, none per write)
// apb      | in  | register writes and reads at byte address 4*index
//
// A query uses the single store port for a decode step and three corner reads
// (one read when off the grid); a write uses it once. The 49-stage divider
// pipe splits x and y into cell and fraction. Reset clears control state only;
// the store holds garbage until written. A stalled output backs up through a
// two-entry result queue into the pipe.
module heightfield_triangle_sampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hts_in_if.sink                      in_i,
  hts_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hts_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hts_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_we;
  logic [2:0]  reg_sel;
  logic        tail_valid, tail_ready;
  tail_t       tail;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols     <= COLS_RST;
      cfg_q.rows     <= ROWS_RST;
      cfg_q.cell_sz  <= CELL_RST;
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_COLS:  cfg_q.cols     <= pwdata[DIM_W-1:0];
        REG_ROWS:  cfg_q.rows     <= pwdata[DIM_W-1:0];
        REG_CELL:  cfg_q.cell_sz  <= pwdata[CELL_W-1:0];
        REG_ORG_X: cfg_q.origin_x <= pwdata;
        REG_ORG_Y: cfg_q.origin_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COLS:  prdata = {23'd0, cfg_q.cols};
      REG_ROWS:  prdata = {23'd0, cfg_q.rows};
      REG_CELL:  prdata = {7'd0, cfg_q.cell_sz};
      REG_ORG_X: prdata = cfg_q.origin_x;
      REG_ORG_Y: prdata = cfg_q.origin_y;
      default:   prdata = '0;
    endcase
  end

  hts_divpipe u_divpipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_action_i  (in_i.action),
    .in_index_i   (in_i.sample_index),
    .in_height_i  (in_i.sample_height),
    .in_qx_i      (in_i.query_x),
    .in_qy_i      (in_i.query_y),
    .tail_valid_o (tail_valid),
    .tail_ready_i (tail_ready),
    .tail_o       (tail)
  );

  hts_lookup u_lookup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .tail_valid_i  (tail_valid),
    .tail_ready_o  (tail_ready),
    .tail_i        (tail),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_height_o  (out_o.height),
    .out_outside_o (out_o.outside)
  );

endmodule

[rtl/hts_checker.sv]
`include "heightfield_triangle_sampler_assert.svh"

module hts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] height_i,
  input logic        outside_i,
  input logic        psel_i,
  input logic        pready_i
);

  // stalled result must hold
  `HTS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(height_i) && $stable(outside_i), "result changed under stall")

  // a point off the grid reads as zero height
  `HTS_ASSERT_IMP(a_outside_zero, out_valid_i && outside_i, height_i == 32'd0,
    "outside result with nonzero height")

  // register port never inserts wait states
  `HTS_ASSERT_IMP(a_no_wait, psel_i, pready_i, "register access stalled")

endmodule

bind heightfield_triangle_sampler hts_checker u_hts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .height_i    (out_o.height),
  .outside_i   (out_o.outside),
  .psel_i      (psel),
  .pready_i    (pready)
);
